// File: hw/rtl/brdo_pkg.sv
// ----------------------------------------------------------------------------
// Broadcast ring package
// Shared widths, request and status codes and defaults for the broadcast ring.
// ----------------------------------------------------------------------------
package brdo_pkg;

    localparam int DEPTH_DEFAULT    = 16;
    localparam int NUM_SUBS_DEFAULT = 4;

    localparam int REQ_W     = 2;
    localparam int SUB_ID_W  = 2;
    localparam int HANDLE_W  = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 32;
    localparam int INDEX_W   = 64;

    // Number of subscribers that sub_id can address.
    localparam int SUB_SLOTS = 2 ** SUB_ID_W;

    localparam logic [COUNT_W-1:0] DROP_MAX = '1;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUBLISH     = 2'd0,
        REQ_SUBSCRIBE   = 2'd1,
        REQ_CONSUME_BEG = 2'd2,
        REQ_CONSUME_END = 2'd3
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_ERROR = 2'd2
    } status_t;

endpackage

// File: hw/rtl/brdo_req_if.sv
// ----------------------------------------------------------------------------
// Broadcast ring request channel
// Valid/ready channel that carries one publish, subscribe or consume request.
// ----------------------------------------------------------------------------
interface brdo_req_if;

    logic                          valid;
    logic                          ready;
    logic [brdo_pkg::REQ_W-1:0]    req_type;
    logic [brdo_pkg::SUB_ID_W-1:0] sub_id;
    logic [brdo_pkg::HANDLE_W-1:0] handle_in;

    modport source (
        output valid,
        output req_type,
        output sub_id,
        output handle_in,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  sub_id,
        input  handle_in,
        output ready
    );

endinterface

// File: hw/rtl/brdo_rsp_if.sv
// ----------------------------------------------------------------------------
// Broadcast ring result channel
// Valid/ready channel that carries the result of one request.
// ----------------------------------------------------------------------------
interface brdo_rsp_if;

    logic                          valid;
    logic                          ready;
    logic [brdo_pkg::STATUS_W-1:0] status;
    logic [brdo_pkg::HANDLE_W-1:0] handle_out;
    logic                          head_dropped;
    logic [brdo_pkg::HANDLE_W-1:0] dropped_handle;
    logic                          entry_valid;
    logic [brdo_pkg::COUNT_W-1:0]  drop_count;

    modport source (
        output valid,
        output status,
        output handle_out,
        output head_dropped,
        output dropped_handle,
        output entry_valid,
        output drop_count,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  handle_out,
        input  head_dropped,
        input  dropped_handle,
        input  entry_valid,
        input  drop_count,
        output ready
    );

endinterface

// File: hw/rtl/broadcast_ring_drop_oldest_unit.sv
// ----------------------------------------------------------------------------
// Broadcast ring, overwrite oldest
// A request passes through the input register and then the result register
// before its result is offered on the result channel.
// One request per cycle while the result side does not stall; the handle store
// has one read and one write port. Reset sets indices, subscriber state and the
// fill count at once; there is no clearing pass and the handle store is never cleared.
// ----------------------------------------------------------------------------
module broadcast_ring_drop_oldest_unit #(
    parameter int DEPTH    = brdo_pkg::DEPTH_DEFAULT,
    parameter int NUM_SUBS = brdo_pkg::NUM_SUBS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    brdo_req_if.sink   req,
    brdo_rsp_if.source rsp
);

    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int FILL_W   = $clog2(DEPTH + 1);
    localparam int INDEX_W  = brdo_pkg::INDEX_W;
    localparam int COUNT_W  = brdo_pkg::COUNT_W;
    localparam int HANDLE_W = brdo_pkg::HANDLE_W;
    localparam int SUBS     = brdo_pkg::SUB_SLOTS;

    localparam logic [ADDR_W-1:0] LAST_SLOT  = ADDR_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_COUNT = FILL_W'(DEPTH);

    // Input register
    logic                            in_valid_reg;
    brdo_pkg::req_type_t             in_type_reg;
    logic [brdo_pkg::SUB_ID_W-1:0]   in_sid_reg;
    logic [HANDLE_W-1:0]             in_handle_reg;

    // Ring state
    logic [INDEX_W-1:0] head_reg;
    logic [INDEX_W-1:0] tail_ptr_reg;
    logic [ADDR_W-1:0]  head_slot_reg;
    logic [ADDR_W-1:0]  tail_slot_reg;
    logic [FILL_W-1:0]  fill_reg;

    logic [INDEX_W-1:0] pos_reg      [SUBS];
    logic [ADDR_W-1:0]  pos_slot_reg [SUBS];
    logic [COUNT_W-1:0] drops_reg    [SUBS];
    logic [SUBS-1:0]    active_reg;

    // Result register
    logic                    out_valid_reg;
    brdo_pkg::status_t       out_status_reg;
    logic                    out_head_dropped_reg;
    logic                    out_entry_valid_reg;
    logic                    out_handle_sel_reg;
    logic [COUNT_W-1:0]      out_drop_count_reg;

    logic                advance;
    logic                fire;
    logic                in_range;

    logic [INDEX_W-1:0]  pos_cur;
    logic [ADDR_W-1:0]   pos_slot_cur;
    logic [COUNT_W-1:0]  drops_cur;
    logic                active_cur;

    logic [INDEX_W-1:0]  pos_new;
    logic [ADDR_W-1:0]   pos_slot_new;
    logic [COUNT_W-1:0]  drops_new;
    logic                active_new;
    logic                sub_we;

    logic [INDEX_W-1:0]  head_next;
    logic [INDEX_W-1:0]  tail_ptr_next;
    logic [ADDR_W-1:0]   head_slot_next;
    logic [ADDR_W-1:0]   tail_slot_next;
    logic [FILL_W-1:0]   fill_next;

    brdo_pkg::status_t   status_res;
    logic                head_dropped_res;
    logic                entry_valid_res;
    logic                handle_sel_res;
    logic [COUNT_W-1:0]  drop_count_res;

    logic                ram_we;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [HANDLE_W-1:0] ram_rdata;

    logic                behind;
    logic [INDEX_W-1:0]  gap;
    logic [COUNT_W-1:0]  jump_drops;
    logic [INDEX_W-1:0]  eff_pos;
    logic [ADDR_W-1:0]   eff_slot;
    logic                empty;

    assign advance   = !out_valid_reg || rsp.ready;
    assign fire      = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;

    assign in_range     = int'(in_sid_reg) < NUM_SUBS;
    assign pos_cur      = pos_reg[in_sid_reg];
    assign pos_slot_cur = pos_slot_reg[in_sid_reg];
    assign drops_cur    = drops_reg[in_sid_reg];
    assign active_cur   = active_reg[in_sid_reg];

    // A subscriber that has fallen behind jumps straight to the oldest live entry.
    assign behind     = pos_cur < head_reg;
    assign gap        = head_reg - pos_cur;
    assign jump_drops = (gap >= {{(INDEX_W - COUNT_W){1'b0}}, ~drops_cur})
                        ? brdo_pkg::DROP_MAX : drops_cur + gap[COUNT_W-1:0];
    assign eff_pos    = behind ? head_reg : pos_cur;
    assign eff_slot   = behind ? head_slot_reg : pos_slot_cur;
    assign empty      = eff_pos == tail_ptr_reg;

    always_comb
    begin
        head_next        = head_reg;
        tail_ptr_next    = tail_ptr_reg;
        head_slot_next   = head_slot_reg;
        tail_slot_next   = tail_slot_reg;
        fill_next        = fill_reg;
        pos_new          = pos_cur;
        pos_slot_new     = pos_slot_cur;
        drops_new        = drops_cur;
        active_new       = active_cur;
        sub_we           = 1'b0;
        status_res       = brdo_pkg::STATUS_OK;
        head_dropped_res = 1'b0;
        entry_valid_res  = 1'b0;
        handle_sel_res   = 1'b0;
        ram_re           = 1'b0;
        ram_raddr        = tail_slot_reg;

        case (in_type_reg)
            brdo_pkg::REQ_PUBLISH:
            begin
                // When the ring is full the tail slot holds the oldest entry.
                ram_re         = 1'b1;
                tail_ptr_next  = tail_ptr_reg + INDEX_W'(1);
                tail_slot_next = (tail_slot_reg == LAST_SLOT) ? '0
                                 : tail_slot_reg + ADDR_W'(1);
                if (fill_reg == FULL_COUNT)
                begin
                    head_dropped_res = 1'b1;
                    head_next        = head_reg + INDEX_W'(1);
                    head_slot_next   = (head_slot_reg == LAST_SLOT) ? '0
                                       : head_slot_reg + ADDR_W'(1);
                end
                else
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
            end
            brdo_pkg::REQ_SUBSCRIBE:
            begin
                if (!in_range)
                begin
                    status_res = brdo_pkg::STATUS_ERROR;
                end
                else
                begin
                    sub_we       = 1'b1;
                    pos_new      = tail_ptr_reg;
                    pos_slot_new = tail_slot_reg;
                    drops_new    = '0;
                    active_new   = 1'b0;
                end
            end
            brdo_pkg::REQ_CONSUME_BEG:
            begin
                if (!in_range || active_cur)
                begin
                    status_res = brdo_pkg::STATUS_ERROR;
                end
                else
                begin
                    sub_we       = 1'b1;
                    pos_new      = eff_pos;
                    pos_slot_new = eff_slot;
                    if (behind)
                    begin
                        drops_new = jump_drops;
                    end
                    if (empty)
                    begin
                        status_res = brdo_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        active_new     = 1'b1;
                        handle_sel_res = 1'b1;
                        ram_re         = 1'b1;
                        ram_raddr      = eff_slot;
                    end
                end
            end
            brdo_pkg::REQ_CONSUME_END:
            begin
                if (!in_range || !active_cur)
                begin
                    status_res = brdo_pkg::STATUS_ERROR;
                end
                else
                begin
                    sub_we          = 1'b1;
                    entry_valid_res = !behind;
                    if (behind && drops_cur != brdo_pkg::DROP_MAX)
                    begin
                        drops_new = drops_cur + COUNT_W'(1);
                    end
                    pos_new      = pos_cur + INDEX_W'(1);
                    pos_slot_new = (pos_slot_cur == LAST_SLOT) ? '0
                                   : pos_slot_cur + ADDR_W'(1);
                    active_new   = 1'b0;
                end
            end
            default:
            begin
                status_res = brdo_pkg::STATUS_ERROR;
            end
        endcase

        drop_count_res = in_range ? drops_new : '0;
    end

    assign ram_we = fire && (in_type_reg == brdo_pkg::REQ_PUBLISH);

    brdo_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (DEPTH)
    ) u_handle_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_slot_reg),
        .wdata (in_handle_reg),
        .re    (fire && ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_type_reg   <= brdo_pkg::req_type_t'(req.req_type);
            in_sid_reg    <= req.sub_id;
            in_handle_reg <= req.handle_in;
        end
    end

    // Ring and subscriber state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= INDEX_W'(1);
            tail_ptr_reg  <= INDEX_W'(1);
            head_slot_reg <= ADDR_W'(1);
            tail_slot_reg <= ADDR_W'(1);
            fill_reg      <= '0;
            active_reg    <= '0;
            for (int i = 0; i < SUBS; i++)
            begin
                pos_reg[i]      <= '0;
                pos_slot_reg[i] <= '0;
                drops_reg[i]    <= '0;
            end
        end
        else if (fire)
        begin
            head_reg      <= head_next;
            tail_ptr_reg  <= tail_ptr_next;
            head_slot_reg <= head_slot_next;
            tail_slot_reg <= tail_slot_next;
            fill_reg      <= fill_next;
            if (sub_we)
            begin
                pos_reg[in_sid_reg]      <= pos_new;
                pos_slot_reg[in_sid_reg] <= pos_slot_new;
                drops_reg[in_sid_reg]    <= drops_new;
                active_reg[in_sid_reg]   <= active_new;
            end
        end
    end

    // Result register; the handles come from the RAM read data, which holds
    // while the result waits for its transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_status_reg       <= status_res;
            out_head_dropped_reg <= head_dropped_res;
            out_entry_valid_reg  <= entry_valid_res;
            out_handle_sel_reg   <= handle_sel_res;
            out_drop_count_reg   <= drop_count_res;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.handle_out     = out_handle_sel_reg ? ram_rdata : '0;
    assign rsp.head_dropped   = out_head_dropped_reg;
    assign rsp.dropped_handle = out_head_dropped_reg ? ram_rdata : '0;
    assign rsp.entry_valid    = out_entry_valid_reg;
    assign rsp.drop_count     = out_drop_count_reg;

endmodule

// File: hw/rtl/brdo_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered, read-first read data.
// ----------------------------------------------------------------------------
module brdo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // A read of the address being written returns the old contents.
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Broadcast ring testbench
// Drives publish, subscribe and consume requests into the ring and checks every
// result against a typed table row or a ring predictor that runs in step with it.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RING_DEPTH  = brdo_pkg::DEPTH_DEFAULT;
    localparam int NUM_SUBS    = brdo_pkg::NUM_SUBS_DEFAULT;
    localparam int INDEX_W     = brdo_pkg::INDEX_W;
    localparam int HANDLE_W    = brdo_pkg::HANDLE_W;
    localparam int COUNT_W     = brdo_pkg::COUNT_W;
    localparam int SUB_ID_W    = brdo_pkg::SUB_ID_W;
    localparam int N_RANDOM    = 870;
    localparam int CYCLE_LIMIT = 300000;
    localparam int N_ROWS      = 18;

    typedef struct packed {
        brdo_pkg::status_t     status;
        logic [HANDLE_W-1:0]   handle_out;
        logic                  head_dropped;
        logic [HANDLE_W-1:0]   dropped_handle;
        logic                  entry_valid;
        logic [COUNT_W-1:0]    drop_count;
    } ring_rsp_t;

    typedef struct packed {
        brdo_pkg::req_type_t   req;
        logic [SUB_ID_W-1:0]   sub_id;
        logic [HANDLE_W-1:0]   handle;
        int                    reps;
        bit                    typed;
        ring_rsp_t             want;
    } stim_row_t;

    localparam ring_rsp_t RSP_NONE = '0;

    logic clk;
    logic rst_n;

    brdo_req_if req_if ();
    brdo_rsp_if rsp_if ();

    broadcast_ring_drop_oldest_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Ring state as the predictor sees it.
    logic [INDEX_W-1:0]  ring_head;
    logic [INDEX_W-1:0]  ring_tail;
    logic [INDEX_W-1:0]  slot_tag_m    [RING_DEPTH];
    logic [HANDLE_W-1:0] slot_handle_m [RING_DEPTH];
    logic [INDEX_W-1:0]  read_pos      [NUM_SUBS];
    logic [COUNT_W-1:0]  drop_total    [NUM_SUBS];
    bit                  consuming     [NUM_SUBS];

    ring_rsp_t   ring_expect_q [$];
    stim_row_t   stim_table [N_ROWS];
    int unsigned n_fail;
    int unsigned cycle_count;
    bit          gaps_on;
    int          stall_left;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int slot_of(logic [INDEX_W-1:0] idx);
        return int'(idx % 64'(RING_DEPTH));
    endfunction

    function automatic logic [COUNT_W-1:0] drops_plus(logic [COUNT_W-1:0] cnt,
                                                       logic [INDEX_W-1:0] gap);
        if (gap >= 64'(brdo_pkg::DROP_MAX - cnt))
            return brdo_pkg::DROP_MAX;
        return cnt + gap[COUNT_W-1:0];
    endfunction

    task automatic reset_ring_model();
        ring_head = 64'd1;
        ring_tail = 64'd1;
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            slot_tag_m[i]    = '0;
            slot_handle_m[i] = '0;
        end
        for (int i = 0; i < NUM_SUBS; i++)
        begin
            read_pos[i]   = '0;
            drop_total[i] = '0;
            consuming[i]  = 1'b0;
        end
    endtask

    // Applies one accepted request to the ring state and gives its result.
    task automatic predict_ring_request(input brdo_pkg::req_type_t rq,
                                        input logic [SUB_ID_W-1:0] sid,
                                        input logic [HANDLE_W-1:0] hnd,
                                        output ring_rsp_t r);
        int  t;
        int  p;
        bit  in_range;
        r = RSP_NONE;
        in_range = int'(sid) < NUM_SUBS;
        if (rq == brdo_pkg::REQ_PUBLISH)
        begin
            t = slot_of(ring_tail);
            if (slot_tag_m[t] != '0 && ring_head <= slot_tag_m[t])
            begin
                r.head_dropped   = 1'b1;
                r.dropped_handle = slot_handle_m[slot_of(ring_head)];
                ring_head++;
            end
            slot_tag_m[t]    = ring_tail;
            slot_handle_m[t] = hnd;
            ring_tail++;
        end
        else if (!in_range)
        begin
            r.status = brdo_pkg::STATUS_ERROR;
        end
        else if (rq == brdo_pkg::REQ_SUBSCRIBE)
        begin
            read_pos[sid]   = ring_tail;
            drop_total[sid] = '0;
            consuming[sid]  = 1'b0;
        end
        else if (rq == brdo_pkg::REQ_CONSUME_BEG)
        begin
            if (consuming[sid])
                r.status = brdo_pkg::STATUS_ERROR;
            else
            begin
                // A subscriber that has fallen behind jumps to the oldest live entry.
                if (read_pos[sid] < ring_head)
                begin
                    drop_total[sid] = drops_plus(drop_total[sid], ring_head - read_pos[sid]);
                    read_pos[sid]   = ring_head;
                end
                p = slot_of(read_pos[sid]);
                if (read_pos[sid] == ring_tail || slot_tag_m[p] != read_pos[sid])
                    r.status = brdo_pkg::STATUS_EMPTY;
                else
                begin
                    r.handle_out   = slot_handle_m[p];
                    consuming[sid] = 1'b1;
                end
            end
        end
        else
        begin
            if (!consuming[sid])
                r.status = brdo_pkg::STATUS_ERROR;
            else
            begin
                if (read_pos[sid] < ring_head)
                    drop_total[sid] = drops_plus(drop_total[sid], 64'd1);
                else
                    r.entry_valid = 1'b1;
                read_pos[sid]++;
                consuming[sid] = 1'b0;
            end
        end
        r.drop_count = in_range ? drop_total[sid] : '0;
    endtask

    // Offers one request, with an occasional gap before it, and waits for the transfer.
    task automatic send_request(input brdo_pkg::req_type_t rq,
                                input logic [SUB_ID_W-1:0] sid,
                                input logic [HANDLE_W-1:0] hnd,
                                output ring_rsp_t predicted);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.req_type  <= rq;
        req_if.sub_id    <= sid;
        req_if.handle_in <= hnd;
        do
            @(posedge clk);
        while (!req_if.ready);
        predict_ring_request(rq, sid, hnd, predicted);
    endtask

    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        while (ring_expect_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            n_fail++;
        end
    endfunction

    // Result side: random stall bursts while gaps are on.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            rsp_if.ready <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            stall_left   <= $urandom_range(0, 9);
            rsp_if.ready <= 1'b0;
        end
        else
            rsp_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        ring_rsp_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (ring_expect_q.size() == 0)
            begin
                $error("result transfer with no request outstanding");
                n_fail++;
            end
            else
            begin
                want = ring_expect_q.pop_front();
                check_field("status", 32'(want.status), 32'(rsp_if.status));
                check_field("handle_out", want.handle_out, rsp_if.handle_out);
                check_field("head_dropped", 32'(want.head_dropped), 32'(rsp_if.head_dropped));
                check_field("dropped_handle", want.dropped_handle, rsp_if.dropped_handle);
                check_field("entry_valid", 32'(want.entry_valid), 32'(rsp_if.entry_valid));
                check_field("drop_count", want.drop_count, rsp_if.drop_count);
            end
        end
    end

    initial
    begin
        ring_rsp_t           predicted;
        brdo_pkg::req_type_t rq;
        logic [SUB_ID_W-1:0] sid;
        logic [HANDLE_W-1:0] hnd;
        int                  pick;
        int                  publish_weight;

        n_fail           = 0;
        cycle_count      = 0;
        stall_left       = 0;
        gaps_on          = 1'b1;
        rst_n            = 1'b0;
        req_if.valid     = 1'b0;
        req_if.req_type  = brdo_pkg::REQ_PUBLISH;
        req_if.sub_id    = '0;
        req_if.handle_in = '0;
        rsp_if.ready     = 1'b0;
        reset_ring_model();

        // Rows with reps above one publish that many random handles.
        stim_table = '{
            '{brdo_pkg::REQ_CONSUME_BEG, 2'd0, 32'h0, 1, 1'b1,
              '{brdo_pkg::STATUS_EMPTY, 32'h0, 1'b0, 32'h0, 1'b0, 32'd1}},
            '{brdo_pkg::REQ_SUBSCRIBE,   2'd0, 32'h0, 1, 1'b1, RSP_NONE},
            '{brdo_pkg::REQ_SUBSCRIBE,   2'd1, 32'h0, 1, 1'b1, RSP_NONE},
            '{brdo_pkg::REQ_PUBLISH,     2'd3, 32'h0, 1, 1'b1, RSP_NONE},
            '{brdo_pkg::REQ_CONSUME_BEG, 2'd0, 32'h0, 1, 1'b1, RSP_NONE},
            '{brdo_pkg::REQ_CONSUME_BEG, 2'd0, 32'h0, 1, 1'b1,
              '{brdo_pkg::STATUS_ERROR, 32'h0, 1'b0, 32'h0, 1'b0, 32'd0}},
            '{brdo_pkg::REQ_CONSUME_END, 2'd0, 32'h0, 1, 1'b1,
              '{brdo_pkg::STATUS_OK, 32'h0, 1'b0, 32'h0, 1'b1, 32'd0}},
            '{brdo_pkg::REQ_PUBLISH,     2'd0, 32'hFFFF_FFFF, 1, 1'b1, RSP_NONE},
            '{brdo_pkg::REQ_CONSUME_BEG, 2'd0, 32'h0, 1, 1'b1,
              '{brdo_pkg::STATUS_OK, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 32'd0}},
            '{brdo_pkg::REQ_CONSUME_BEG, 2'd1, 32'h0, 1, 1'b1, RSP_NONE},
            '{brdo_pkg::REQ_PUBLISH,     2'd1, 32'h0, 14, 1'b0, RSP_NONE},
            '{brdo_pkg::REQ_PUBLISH,     2'd2, 32'hA5A5_5A5A, 1, 1'b1,
              '{brdo_pkg::STATUS_OK, 32'h0, 1'b1, 32'h0, 1'b0, 32'd0}},
            '{brdo_pkg::REQ_CONSUME_END, 2'd1, 32'h0, 1, 1'b1,
              '{brdo_pkg::STATUS_OK, 32'h0, 1'b0, 32'h0, 1'b0, 32'd1}},
            '{brdo_pkg::REQ_PUBLISH,     2'd3, 32'h1234_0000, 1, 1'b1,
              '{brdo_pkg::STATUS_OK, 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'd0}},
            '{brdo_pkg::REQ_CONSUME_END, 2'd0, 32'h0, 1, 1'b0, RSP_NONE},
            '{brdo_pkg::REQ_CONSUME_BEG, 2'd2, 32'h0, 1, 1'b0, RSP_NONE},
            '{brdo_pkg::REQ_SUBSCRIBE,   2'd2, 32'h0, 1, 1'b1, RSP_NONE},
            '{brdo_pkg::REQ_CONSUME_END, 2'd2, 32'h0, 1, 1'b1,
              '{brdo_pkg::STATUS_ERROR, 32'h0, 1'b0, 32'h0, 1'b0, 32'd0}}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            for (int k = 0; k < stim_table[i].reps; k++)
            begin
                hnd = (stim_table[i].reps > 1) ? $urandom() : stim_table[i].handle;
                send_request(stim_table[i].req, stim_table[i].sub_id, hnd, predicted);
                ring_expect_q.push_back(stim_table[i].typed ? stim_table[i].want : predicted);
            end
        end
        wait_for_results();

        // Random part: mostly well-formed begin/end pairs, with spells of heavy
        // publishing so that subscribers fall behind, and some misuse mixed in.
        publish_weight = 35;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            gaps_on = (n < N_RANDOM - 150) && ((n / 100) % 3 != 2);
            if (n % 60 == 0)
                publish_weight = 15 + 25 * $urandom_range(0, 2);
            if (n == 400)
                wait_for_results();
            sid  = $urandom_range(0, brdo_pkg::SUB_SLOTS - 1);
            hnd  = $urandom();
            pick = $urandom_range(0, 99);
            if (pick < publish_weight)
                rq = brdo_pkg::REQ_PUBLISH;
            else if (pick < publish_weight + 5)
                rq = brdo_pkg::REQ_SUBSCRIBE;
            else if (pick < publish_weight + 12)
                rq = (int'(sid) < NUM_SUBS && consuming[sid])
                     ? brdo_pkg::REQ_CONSUME_BEG : brdo_pkg::REQ_CONSUME_END;
            else
                rq = (int'(sid) < NUM_SUBS && consuming[sid])
                     ? brdo_pkg::REQ_CONSUME_END : brdo_pkg::REQ_CONSUME_BEG;
            send_request(rq, sid, hnd, predicted);
            ring_expect_q.push_back(predicted);
        end
        wait_for_results();
        repeat (10) @(posedge clk);

        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/brdo_pkg.sv
hw/rtl/brdo_req_if.sv
hw/rtl/brdo_rsp_if.sv
hw/rtl/brdo_ram.sv
hw/rtl/broadcast_ring_drop_oldest_unit.sv
tb/testbench.sv
